FILE: hdl/psq_pkg.sv
// Package with the shared types and region codes of the point-to-segment query.
`timescale 1ns / 1ps
`default_nettype none

package psq_pkg;

  typedef logic [1:0] region_t;

  // Region codes of a result.
  localparam region_t REGION_START = 2'd0;
  localparam region_t REGION_END   = 2'd1;
  localparam region_t REGION_LEFT  = 2'd2;
  localparam region_t REGION_RIGHT = 2'd3;

endpackage

`default_nettype wire

FILE: hdl/point_segment_query.sv
// Pipelined closest point on a 2D segment, with region and distance of a query point.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------------
//   in_     | sink      | in_valid / in_stall  | start, end and query point (x, y)
//   out_    | source    | out_valid/out_stall | region, nearest point, distance
//
// One request enters in every cycle while in_stall is low; it passes through
// six arithmetic stages, COORD_BITS + 1 digit stages and the output register.
// The depth is set by the digit stages, one quotient and one root bit per stage.
// Reset is synchronous and active low; it clears the valid bits and the skid entry.
// A stalled output parks one result in a skid register; while that is full the whole
// pipeline holds and in_stall is raised, so nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module point_segment_query #(
  parameter int COORD_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire signed [COORD_BITS-1:0]  in_start_x,
  input  wire signed [COORD_BITS-1:0]  in_start_y,
  input  wire signed [COORD_BITS-1:0]  in_end_x,
  input  wire signed [COORD_BITS-1:0]  in_end_y,
  input  wire signed [COORD_BITS-1:0]  in_query_x,
  input  wire signed [COORD_BITS-1:0]  in_query_y,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [1:0]                   out_region,
  output logic signed [COORD_BITS-1:0] out_nearest_x,
  output logic signed [COORD_BITS-1:0] out_nearest_y,
  output logic [COORD_BITS:0]          out_distance
);

  // Widths. All coordinates share one scale, so the fraction width plays no part.
  localparam int CW  = COORD_BITS;     // coordinate
  localparam int DW  = CW + 1;         // signed coordinate difference
  localparam int MW  = 2 * DW;         // signed product of two differences
  localparam int LW  = 2 * CW + 1;     // squared length, positive dot, |cross|
  localparam int SW  = 2 * CW + 2;     // signed dot and cross product
  localparam int HL  = CW + 1;         // low half when a LW-bit value is split
  localparam int PW  = 3 * CW + 1;     // |d| * dot
  localparam int NW  = 4 * CW + 2;     // cross squared
  localparam int TW  = 4 * CW + 3;     // trial value of the root recurrence
  localparam int RLW = 3 * CW + 2;     // partial root times divisor
  localparam int KS  = CW + 1;         // digit stages, one bit each

  // The pipeline moves as a whole whenever the skid register is empty.
  logic en;
  logic skid_v_r;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // ---------------------------------------------------------------------------
  // Stage 1: differences.
  // ---------------------------------------------------------------------------
  logic                 s1_v_r;
  logic signed [DW-1:0] s1_dx_r, s1_dy_r, s1_wx_r, s1_wy_r, s1_ux_r, s1_uy_r;
  logic [CW-1:0]        s1_sx_r, s1_sy_r, s1_ex_r, s1_ey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_valid;
      s1_dx_r <= DW'(in_end_x) - DW'(in_start_x);
      s1_dy_r <= DW'(in_end_y) - DW'(in_start_y);
      s1_wx_r <= DW'(in_query_x) - DW'(in_start_x);
      s1_wy_r <= DW'(in_query_y) - DW'(in_start_y);
      s1_ux_r <= DW'(in_query_x) - DW'(in_end_x);
      s1_uy_r <= DW'(in_query_y) - DW'(in_end_y);
      s1_sx_r <= in_start_x;
      s1_sy_r <= in_start_y;
      s1_ex_r <= in_end_x;
      s1_ey_r <= in_end_y;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the ten products of differences.
  // ---------------------------------------------------------------------------
  logic                 s2_v_r;
  logic signed [MW-1:0] s2_dxdx_r, s2_dydy_r, s2_dxwx_r, s2_dywy_r, s2_dxwy_r, s2_dywx_r;
  logic signed [MW-1:0] s2_wxwx_r, s2_wywy_r, s2_uxux_r, s2_uyuy_r;
  logic signed [DW-1:0] s2_dx_r, s2_dy_r;
  logic [CW-1:0]        s2_sx_r, s2_sy_r, s2_ex_r, s2_ey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r    <= s1_v_r;
      s2_dxdx_r <= s1_dx_r * s1_dx_r;
      s2_dydy_r <= s1_dy_r * s1_dy_r;
      s2_dxwx_r <= s1_dx_r * s1_wx_r;
      s2_dywy_r <= s1_dy_r * s1_wy_r;
      s2_dxwy_r <= s1_dx_r * s1_wy_r;
      s2_dywx_r <= s1_dy_r * s1_wx_r;
      s2_wxwx_r <= s1_wx_r * s1_wx_r;
      s2_wywy_r <= s1_wy_r * s1_wy_r;
      s2_uxux_r <= s1_ux_r * s1_ux_r;
      s2_uyuy_r <= s1_uy_r * s1_uy_r;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_sx_r   <= s1_sx_r;
      s2_sy_r   <= s1_sy_r;
      s2_ex_r   <= s1_ex_r;
      s2_ey_r   <= s1_ey_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squared length, dot and cross product, squared distances to the ends.
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] len2_full, pw_full, pu_full;

  assign len2_full = s2_dxdx_r + s2_dydy_r;
  assign pw_full   = s2_wxwx_r + s2_wywy_r;
  assign pu_full   = s2_uxux_r + s2_uyuy_r;

  logic                 s3_v_r;
  logic [LW-1:0]        s3_len2_r, s3_pw_r, s3_pu_r;
  logic signed [SW-1:0] s3_dot_r, s3_crs_r;
  logic signed [DW-1:0] s3_dx_r, s3_dy_r;
  logic [CW-1:0]        s3_sx_r, s3_sy_r, s3_ex_r, s3_ey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r    <= s2_v_r;
      s3_len2_r <= len2_full[LW-1:0];
      s3_pw_r   <= pw_full[LW-1:0];
      s3_pu_r   <= pu_full[LW-1:0];
      s3_dot_r  <= s2_dxwx_r + s2_dywy_r;
      s3_crs_r  <= s2_dxwy_r - s2_dywx_r;
      s3_dx_r   <= s2_dx_r;
      s3_dy_r   <= s2_dy_r;
      s3_sx_r   <= s2_sx_r;
      s3_sy_r   <= s2_sy_r;
      s3_ex_r   <= s2_ex_r;
      s3_ey_r   <= s2_ey_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: region decision and magnitudes.
  // A zero-length segment or a projection at or before the start gives the start
  // region; a projection at or past the end gives the end region. Inside the span
  // the side follows the sign of the cross product, a zero cross counting as left.
  // ---------------------------------------------------------------------------
  psq_pkg::region_t     region_nxt;
  logic                 inside_nxt;
  logic signed [DW-1:0] ndx, ndy;
  logic signed [SW-1:0] ncrs;

  assign ndx  = -s3_dx_r;
  assign ndy  = -s3_dy_r;
  assign ncrs = -s3_crs_r;

  always_comb begin
    if (s3_len2_r == '0 || s3_dot_r[SW-1] || s3_dot_r == '0) begin
      region_nxt = psq_pkg::REGION_START;
    end else if (s3_dot_r[LW-1:0] >= s3_len2_r) begin
      region_nxt = psq_pkg::REGION_END;
    end else if (s3_crs_r[SW-1]) begin
      region_nxt = psq_pkg::REGION_RIGHT;
    end else begin
      region_nxt = psq_pkg::REGION_LEFT;
    end
    inside_nxt = (region_nxt == psq_pkg::REGION_LEFT) ||
                 (region_nxt == psq_pkg::REGION_RIGHT);
  end

  logic             s4_v_r;
  psq_pkg::region_t s4_region_r;
  logic             s4_inside_r;
  logic [CW-1:0]    s4_bx_r, s4_by_r, s4_adx_r, s4_ady_r;
  logic             s4_negx_r, s4_negy_r;
  logic [LW-1:0]    s4_dot_r, s4_acrs_r, s4_len2_r, s4_pt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r      <= s3_v_r;
      s4_region_r <= region_nxt;
      s4_inside_r <= inside_nxt;
      s4_bx_r     <= (region_nxt == psq_pkg::REGION_END) ? s3_ex_r : s3_sx_r;
      s4_by_r     <= (region_nxt == psq_pkg::REGION_END) ? s3_ey_r : s3_sy_r;
      s4_adx_r    <= s3_dx_r[DW-1] ? ndx[CW-1:0] : s3_dx_r[CW-1:0];
      s4_ady_r    <= s3_dy_r[DW-1] ? ndy[CW-1:0] : s3_dy_r[CW-1:0];
      s4_negx_r   <= s3_dx_r[DW-1];
      s4_negy_r   <= s3_dy_r[DW-1];
      s4_dot_r    <= s3_dot_r[LW-1:0];
      s4_acrs_r   <= s3_crs_r[SW-1] ? ncrs[LW-1:0] : s3_crs_r[LW-1:0];
      s4_len2_r   <= s3_len2_r;
      s4_pt_r     <= (region_nxt == psq_pkg::REGION_END) ? s3_pu_r : s3_pw_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: partial products of |d| * dot and of cross squared, split in halves.
  // ---------------------------------------------------------------------------
  logic                 s5_v_r;
  psq_pkg::region_t     s5_region_r;
  logic                 s5_inside_r;
  logic [CW-1:0]        s5_bx_r, s5_by_r;
  logic                 s5_negx_r, s5_negy_r;
  logic [LW-1:0]        s5_pxl_r, s5_pyl_r, s5_clh_r, s5_len2_r, s5_pt_r;
  logic [2*CW-1:0]      s5_pxh_r, s5_pyh_r, s5_chh_r;
  logic [2*HL-1:0]      s5_cll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r      <= s4_v_r;
      s5_region_r <= s4_region_r;
      s5_inside_r <= s4_inside_r;
      s5_bx_r     <= s4_bx_r;
      s5_by_r     <= s4_by_r;
      s5_negx_r   <= s4_negx_r;
      s5_negy_r   <= s4_negy_r;
      s5_pxl_r    <= s4_adx_r * s4_dot_r[HL-1:0];
      s5_pxh_r    <= s4_adx_r * s4_dot_r[LW-1:HL];
      s5_pyl_r    <= s4_ady_r * s4_dot_r[HL-1:0];
      s5_pyh_r    <= s4_ady_r * s4_dot_r[LW-1:HL];
      s5_cll_r    <= s4_acrs_r[HL-1:0] * s4_acrs_r[HL-1:0];
      s5_clh_r    <= s4_acrs_r[HL-1:0] * s4_acrs_r[LW-1:HL];
      s5_chh_r    <= s4_acrs_r[LW-1:HL] * s4_acrs_r[LW-1:HL];
      s5_len2_r   <= s4_len2_r;
      s5_pt_r     <= s4_pt_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: assemble the wide products and load the digit stages.
  // Inside the span the distance is floor(sqrt(cross^2 / len2)); at the ends it is
  // floor(sqrt(squared distance)), which is the same recurrence with divisor one.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] pxm, pym;
  logic [NW-1:0] c2;

  assign pxm = (PW'(s5_pxh_r) << HL) + PW'(s5_pxl_r);
  assign pym = (PW'(s5_pyh_r) << HL) + PW'(s5_pyl_r);
  assign c2  = (NW'(s5_chh_r) << (2 * HL)) + (NW'(s5_clh_r) << (HL + 1)) + NW'(s5_cll_r);

  logic             it_v_r      [0:KS];
  psq_pkg::region_t it_region_r [0:KS];
  logic             it_inside_r [0:KS];
  logic [CW-1:0]    it_bx_r     [0:KS];
  logic [CW-1:0]    it_by_r     [0:KS];
  logic             it_negx_r   [0:KS];
  logic             it_negy_r   [0:KS];
  logic [LW-1:0]    it_len_r    [0:KS];
  logic [PW-1:0]    it_xn_r     [0:KS];
  logic [PW-1:0]    it_yn_r     [0:KS];
  logic [LW-1:0]    it_xr_r     [0:KS];
  logic [LW-1:0]    it_yr_r     [0:KS];
  logic [KS-1:0]    it_xq_r     [0:KS];
  logic [KS-1:0]    it_yq_r     [0:KS];
  logic [LW-1:0]    it_dl_r     [0:KS];
  logic [NW-1:0]    it_rem_r    [0:KS];
  logic [RLW-1:0]   it_rl_r     [0:KS];
  logic [KS-1:0]    it_root_r   [0:KS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_v_r[0] <= 1'b0;
    end else if (en) begin
      it_v_r[0]      <= s5_v_r;
      it_region_r[0] <= s5_region_r;
      it_inside_r[0] <= s5_inside_r;
      it_bx_r[0]     <= s5_bx_r;
      it_by_r[0]     <= s5_by_r;
      it_negx_r[0]   <= s5_negx_r;
      it_negy_r[0]   <= s5_negy_r;
      it_len_r[0]    <= s5_len2_r;
      it_xn_r[0]     <= pxm;
      it_yn_r[0]     <= pym;
      it_xr_r[0]     <= LW'(pxm >> KS);
      it_yr_r[0]     <= LW'(pym >> KS);
      it_xq_r[0]     <= '0;
      it_yq_r[0]     <= '0;
      it_dl_r[0]     <= s5_inside_r ? s5_len2_r : LW'(1);
      it_rem_r[0]    <= s5_inside_r ? c2 : NW'(s5_pt_r);
      it_rl_r[0]     <= '0;
      it_root_r[0]   <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Digit stages: one restoring-division bit for each coordinate and one root bit
  // of the distance per stage. The root keeps r*L so that each trial is
  // (r*L << (b+1)) + (L << 2b) against the remaining numerator.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < KS; k++) begin : gen_digit
    localparam int B = KS - 1 - k;

    logic [LW:0]    xsh, ysh, xdif, ydif;
    logic           xge, yge, dge;
    logic [LW-1:0]  xr_nxt, yr_nxt;
    logic [TW-1:0]  trial, rem_w;
    logic [NW-1:0]  rem_nxt;
    logic [RLW-1:0] rl_nxt;
    logic [KS-1:0]  bit_b;

    assign bit_b = KS'(1) << B;

    always_comb begin
      xsh     = {it_xr_r[k], it_xn_r[k][B]};
      ysh     = {it_yr_r[k], it_yn_r[k][B]};
      xdif    = xsh - {1'b0, it_len_r[k]};
      ydif    = ysh - {1'b0, it_len_r[k]};
      xge     = xsh >= {1'b0, it_len_r[k]};
      yge     = ysh >= {1'b0, it_len_r[k]};
      xr_nxt  = xge ? xdif[LW-1:0] : xsh[LW-1:0];
      yr_nxt  = yge ? ydif[LW-1:0] : ysh[LW-1:0];
      trial   = (TW'(it_rl_r[k]) << (B + 1)) + (TW'(it_dl_r[k]) << (2 * B));
      rem_w   = TW'(it_rem_r[k]);
      dge     = rem_w >= trial;
      rem_nxt = dge ? NW'(rem_w - trial) : it_rem_r[k];
      rl_nxt  = dge ? (it_rl_r[k] + (RLW'(it_dl_r[k]) << B)) : it_rl_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        it_v_r[k+1] <= 1'b0;
      end else if (en) begin
        it_v_r[k+1]      <= it_v_r[k];
        it_region_r[k+1] <= it_region_r[k];
        it_inside_r[k+1] <= it_inside_r[k];
        it_bx_r[k+1]     <= it_bx_r[k];
        it_by_r[k+1]     <= it_by_r[k];
        it_negx_r[k+1]   <= it_negx_r[k];
        it_negy_r[k+1]   <= it_negy_r[k];
        it_len_r[k+1]    <= it_len_r[k];
        it_xn_r[k+1]     <= it_xn_r[k];
        it_yn_r[k+1]     <= it_yn_r[k];
        it_xr_r[k+1]     <= xr_nxt;
        it_yr_r[k+1]     <= yr_nxt;
        it_xq_r[k+1]     <= xge ? (it_xq_r[k] | bit_b) : it_xq_r[k];
        it_yq_r[k+1]     <= yge ? (it_yq_r[k] | bit_b) : it_yq_r[k];
        it_dl_r[k+1]     <= it_dl_r[k];
        it_rem_r[k+1]    <= rem_nxt;
        it_rl_r[k+1]     <= rl_nxt;
        it_root_r[k+1]   <= dge ? (it_root_r[k] | bit_b) : it_root_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final step: the offset along the segment rounds towards minus infinity, so a
  // negative product takes the ceiling of its magnitude before the sign goes back.
  // ---------------------------------------------------------------------------
  logic [KS-1:0] qx_sum, qy_sum;
  logic [CW-1:0] offx, offy;
  logic [CW-1:0] fin_x, fin_y;

  always_comb begin
    qx_sum = it_xq_r[KS] + KS'(it_xr_r[KS] != '0 && it_negx_r[KS]);
    qy_sum = it_yq_r[KS] + KS'(it_yr_r[KS] != '0 && it_negy_r[KS]);
    offx   = it_negx_r[KS] ? (CW'(0) - qx_sum[CW-1:0]) : qx_sum[CW-1:0];
    offy   = it_negy_r[KS] ? (CW'(0) - qy_sum[CW-1:0]) : qy_sum[CW-1:0];
    fin_x  = it_inside_r[KS] ? (it_bx_r[KS] + offx) : it_bx_r[KS];
    fin_y  = it_inside_r[KS] ? (it_by_r[KS] + offy) : it_by_r[KS];
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid entry.
  // ---------------------------------------------------------------------------
  logic             push;
  logic             out_valid_r;
  psq_pkg::region_t out_region_r, skid_region_r;
  logic [CW-1:0]    out_x_r, out_y_r, skid_x_r, skid_y_r;
  logic [CW:0]      out_dist_r, skid_dist_r;

  assign push = en && it_v_r[KS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= skid_v_r || push;
      skid_v_r    <= 1'b0;
    end else if (push) begin
      skid_v_r    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_region_r <= skid_v_r ? skid_region_r : it_region_r[KS];
      out_x_r      <= skid_v_r ? skid_x_r : fin_x;
      out_y_r      <= skid_v_r ? skid_y_r : fin_y;
      out_dist_r   <= skid_v_r ? skid_dist_r : it_root_r[KS];
    end else if (push) begin
      skid_region_r <= it_region_r[KS];
      skid_x_r      <= fin_x;
      skid_y_r      <= fin_y;
      skid_dist_r   <= it_root_r[KS];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_region    = out_region_r;
  assign out_nearest_x = out_x_r;
  assign out_nearest_y = out_y_r;
  assign out_distance  = out_dist_r;

endmodule

`default_nettype wire

FILE: hdl/psq_checker.sv
// Port-level assertions for the point-to-segment query, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module psq_checker #(
  parameter int COORD_BITS = 32
) (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_stall,
  input wire                  out_valid,
  input wire                  out_stall,
  input wire [1:0]            out_region,
  input wire [COORD_BITS-1:0] out_nearest_x,
  input wire [COORD_BITS-1:0] out_nearest_y,
  input wire [COORD_BITS:0]   out_distance
);

  // No result is offered straight after reset.
  a_reset_idle: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result offered straight after reset");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid &&
      $stable({out_region, out_nearest_x, out_nearest_y, out_distance}))
    else $error("stalled result changed");

  // Requests are refused only while a result is waiting at the output.
  a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
      in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // The input is stalled only after the output itself was stalled.
  a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
      $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall raised without an output stall");

  // The input is released only once the waiting result has been taken.
  a_stall_fall: assert property (@(posedge clk) disable iff (!rst_n)
      $fell(in_stall) |-> $past(!out_stall))
    else $error("input stall dropped while output still stalled");

endmodule

bind point_segment_query psq_checker #(.COORD_BITS(COORD_BITS)) u_psq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_region    (out_region),
  .out_nearest_x (out_nearest_x),
  .out_nearest_y (out_nearest_y),
  .out_distance  (out_distance)
);

`default_nettype wire
